// ===== src/ctsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared codes, widths and small arithmetic helpers for the clock time-set
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsc_pkg;

    // Field widths
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int TIMER_W = 17;
    localparam int EL_W    = 10;
    localparam int CFG_W   = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // Item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // Press / held button codes
    localparam logic [1:0] BTN_NONE    = 2'd0;
    localparam logic [1:0] BTN_SET     = 2'd1;
    localparam logic [1:0] BTN_ADJUST  = 2'd2;
    localparam logic [1:0] BTN_OUTSIDE = 2'd3;

    // Edit phases
    localparam logic [1:0] PHASE_HOUR   = 2'd1;
    localparam logic [1:0] PHASE_MINUTE = 2'd2;
    localparam logic [1:0] PHASE_FINAL  = 2'd3;

    // Display masks
    localparam logic [1:0] SHOW_NONE   = 2'b00;
    localparam logic [1:0] SHOW_HOUR   = 2'b01;
    localparam logic [1:0] SHOW_MINUTE = 2'b10;
    localparam logic [1:0] SHOW_BOTH   = 2'b11;

    // Result status codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EDITING   = 3'd1;
    localparam logic [2:0] ST_SAVED     = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_BLINK_PERIOD = 1'b0;
    localparam logic CFG_IDLE_TIMEOUT = 1'b1;

    localparam logic [CFG_W-1:0] BLINK_PERIOD_RST = 16'd500;
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd30000;

    // 8-bit value mod 24 by restoring subtraction (quotient fits 4 bits)
    function automatic logic [HOUR_W-1:0] mod24(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[HOUR_W-1:0];
    endfunction

    // 8-bit value mod 60 by restoring subtraction (quotient fits 3 bits)
    function automatic logic [MIN_W-1:0] mod60(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[MIN_W-1:0];
    endfunction

    // Saturating timer add
    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [EL_W-1:0]    b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {{(TIMER_W+1-EL_W){1'b0}}, b};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/clock_time_set_controller.sv =====
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Two-button time-set controller: start loads hour/minute, polls step the
// edit through hour, minute and save or cancel, with blink and idle timeout.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | op start_hour start_minute press released
//          |                     | elapsed_ms
//  out     | out_valid/out_stall | hour minute show_mask repaint held_button status
//  cfg     | cfg_write           | cfg_index cfg_data
//
//  One item per cycle unless stalled; each accepted beat gives a result next cycle.
//  All item logic sits between the state registers and the result register.
//  in_stall rises only while a result is held by out_stall.
//  Reset: not editing, phase hour, timers and blink cleared, 500/30000 ms cfg.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_set_controller
    import ctsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [7:0]        start_hour,
    input  wire logic [7:0]        start_minute,
    input  wire logic [1:0]        press,
    input  wire logic              released,
    input  wire logic [EL_W-1:0]   elapsed_ms,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [HOUR_W-1:0]      hour,
    output logic [MIN_W-1:0]       minute,
    output logic [1:0]             show_mask,
    output logic                   repaint,
    output logic [1:0]             held_button,
    output logic [2:0]             status
);

    // Configuration registers
    logic [CFG_W-1:0]   blink_period_reg;
    logic [CFG_W-1:0]   idle_timeout_reg;

    // Edit state
    logic               editing_reg,   editing_next;
    logic [HOUR_W-1:0]  hour_st_reg,   hour_st_next;
    logic [MIN_W-1:0]   min_st_reg,    min_st_next;
    logic [1:0]         phase_reg,     phase_next;
    logic [1:0]         held_reg,      held_next;
    logic               blink_reg,     blink_next;
    logic [TIMER_W-1:0] blink_el_reg,  blink_el_next;
    logic [TIMER_W-1:0] idle_el_reg,   idle_el_next;

    // Result register
    logic               out_valid_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   minute_reg;
    logic [1:0]         mask_reg,      mask_next;
    logic               repaint_reg,   repaint_next;
    logic [1:0]         held_out_reg,  held_out_next;
    logic [2:0]         status_reg,    status_next;

    logic               in_accept;
    logic               out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !out_free;
    assign in_accept = in_valid && out_free;

    // Per-item next state and result
    always_comb
    begin
        logic pressed;
        logic done;
        logic upd;

        editing_next  = editing_reg;
        hour_st_next  = hour_st_reg;
        min_st_next   = min_st_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        blink_next    = blink_reg;
        blink_el_next = blink_el_reg;
        idle_el_next  = idle_el_reg;
        mask_next     = SHOW_NONE;
        repaint_next  = 1'b0;
        held_out_next = BTN_NONE;
        status_next   = ST_IDLE;
        pressed       = 1'b0;
        done          = 1'b0;
        upd           = 1'b0;

        if (op == OP_START)
        begin
            hour_st_next  = mod24(start_hour);
            min_st_next   = mod60(start_minute);
            editing_next  = 1'b1;
            phase_next    = PHASE_HOUR;
            held_next     = BTN_NONE;
            blink_next    = 1'b0;
            blink_el_next = '0;
            idle_el_next  = '0;
            mask_next     = SHOW_BOTH;
            repaint_next  = 1'b1;
            status_next   = ST_EDITING;
        end
        else if (editing_reg)
        begin
            // button events
            if (held_reg == BTN_NONE)
            begin
                unique case (press)
                    BTN_OUTSIDE:
                    begin
                        done        = 1'b1;
                        status_next = ST_CANCELLED;
                    end
                    BTN_SET:
                        phase_next = (phase_reg == PHASE_HOUR) ? PHASE_MINUTE : PHASE_FINAL;
                    BTN_ADJUST:
                    begin
                        if (phase_reg == PHASE_HOUR)
                            hour_st_next = (hour_st_reg == HOUR_W'(23)) ? '0
                                                                        : hour_st_reg + 1'b1;
                        else
                            min_st_next = (min_st_reg == MIN_W'(59)) ? '0
                                                                     : min_st_reg + 1'b1;
                    end
                    default: ;
                endcase
                if (!done && press != BTN_NONE)
                begin
                    held_next     = press;
                    pressed       = 1'b1;
                    upd           = 1'b1;
                    blink_next    = 1'b0;
                    blink_el_next = '0;
                    idle_el_next  = '0;
                end
            end
            else
            begin
                if (released)
                begin
                    held_next = BTN_NONE;
                    if (phase_reg == PHASE_FINAL)
                    begin
                        done        = 1'b1;
                        status_next = ST_SAVED;
                    end
                end
                upd = released;
            end

            // timers, blink and timeout
            if (!done)
            begin
                if (!pressed)
                begin
                    blink_el_next = sat_add(blink_el_reg, elapsed_ms);
                    idle_el_next  = sat_add(idle_el_reg, elapsed_ms);
                end
                if (blink_el_next > {1'b0, blink_period_reg})
                begin
                    blink_next    = !blink_next;
                    upd           = 1'b1;
                    blink_el_next = '0;
                end
                if (idle_el_next > {1'b0, idle_timeout_reg})
                begin
                    done        = 1'b1;
                    status_next = ST_TIMEOUT;
                end
            end

            if (done)
            begin
                editing_next = 1'b0;
                held_next    = BTN_NONE;
                mask_next    = SHOW_BOTH;
            end
            else
            begin
                mask_next = SHOW_BOTH;
                if (blink_next)
                begin
                    if (phase_next == PHASE_HOUR)
                        mask_next = SHOW_MINUTE;
                    else if (phase_next == PHASE_MINUTE)
                        mask_next = SHOW_HOUR;
                end
                repaint_next  = upd;
                held_out_next = held_next;
                status_next   = ST_EDITING;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg <= BLINK_PERIOD_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data;
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Edit state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            editing_reg  <= 1'b0;
            hour_st_reg  <= '0;
            min_st_reg   <= '0;
            phase_reg    <= PHASE_HOUR;
            held_reg     <= BTN_NONE;
            blink_reg    <= 1'b0;
            blink_el_reg <= '0;
            idle_el_reg  <= '0;
        end
        else if (in_accept)
        begin
            editing_reg  <= editing_next;
            hour_st_reg  <= hour_st_next;
            min_st_reg   <= min_st_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            blink_reg    <= blink_next;
            blink_el_reg <= blink_el_next;
            idle_el_reg  <= idle_el_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hour_reg     <= hour_st_next;
            minute_reg   <= min_st_next;
            mask_reg     <= mask_next;
            repaint_reg  <= repaint_next;
            held_out_reg <= held_out_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hour        = hour_reg;
    assign minute      = minute_reg;
    assign show_mask   = mask_reg;
    assign repaint     = repaint_reg;
    assign held_button = held_out_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // an accepted beat always yields a result next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted item produced no result");

    // edited values stay in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour < HOUR_W'(24)) && (minute < MIN_W'(60)))
        else $error("hour or minute out of range");

    // idle results show nothing and never repaint
    a_idle_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_IDLE) |-> (show_mask == SHOW_NONE) && !repaint
                                          && (held_button == BTN_NONE))
        else $error("idle result not blank");

    // exits show both fields with no button held and leave editing
    a_exit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_SAVED || status == ST_CANCELLED
                       || status == ST_TIMEOUT))
        |-> (show_mask == SHOW_BOTH) && !repaint && (held_button == BTN_NONE)
            && !editing_reg && (held_reg == BTN_NONE))
        else $error("exit result inconsistent");

    // phase code is never zero
    a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd0)
        else $error("edit phase corrupt");
`endif

endmodule

`default_nettype wire

// ===== dv/ctsc_checker.sv =====
// ----------------------------------------------------------------------------
// ctsc_checker
// Watches the item, result and register ports of the clock time-set
// controller. It keeps its own copy of the edit state, predicts each result
// as an item beat is taken, and compares results field by field in order.
// ----------------------------------------------------------------------------
module ctsc_checker
    import ctsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              op,
    input  logic [7:0]        start_hour,
    input  logic [7:0]        start_minute,
    input  logic [1:0]        press,
    input  logic              released,
    input  logic [EL_W-1:0]   elapsed_ms,

    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [HOUR_W-1:0] hour,
    input  logic [MIN_W-1:0]  minute,
    input  logic [1:0]        show_mask,
    input  logic              repaint,
    input  logic [1:0]        held_button,
    input  logic [2:0]        status,

    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [1:0]        mask;
        logic              repaint;
        logic [1:0]        held;
        logic [2:0]        status;
    } clock_view_t;

    // Edit state and register copies
    logic [CFG_W-1:0]   blink_period;
    logic [CFG_W-1:0]   idle_timeout;
    logic               editing;
    logic [HOUR_W-1:0]  ed_hour;
    logic [MIN_W-1:0]   ed_min;
    logic [1:0]         phase;
    logic [1:0]         held_btn;
    logic               blink;
    logic [TIMER_W-1:0] blink_ms;
    logic [TIMER_W-1:0] idle_ms;

    clock_view_t expected_views[$];
    clock_view_t want;

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $time, what);
        errors++;
    endtask

    // Timers stick at all ones
    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                     input logic [EL_W-1:0]    ms);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + ms;
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    function automatic clock_view_t show_view(input logic [1:0] mask, input logic rep,
                                              input logic [1:0] hb, input logic [2:0] st);
        clock_view_t v;
        v.hour    = ed_hour;
        v.minute  = ed_min;
        v.mask    = mask;
        v.repaint = rep;
        v.held    = hb;
        v.status  = st;
        return v;
    endfunction

    // Save, cancel and timeout all leave editing the same way
    function automatic clock_view_t close_edit(input logic [2:0] st);
        editing  = 1'b0;
        held_btn = BTN_NONE;
        return show_view(SHOW_BOTH, 1'b0, BTN_NONE, st);
    endfunction

    function automatic clock_view_t predict_view(input logic op_i, input logic [7:0] hr_i,
                                                 input logic [7:0] mn_i, input logic [1:0] pr_i,
                                                 input logic rel_i, input logic [EL_W-1:0] el_i);
        logic       upd;
        logic       pressed;
        logic [1:0] mask;
        upd     = 1'b0;
        pressed = 1'b0;

        if (op_i == OP_START)
        begin
            ed_hour  = HOUR_W'(hr_i % 24);
            ed_min   = MIN_W'(mn_i % 60);
            editing  = 1'b1;
            phase    = PHASE_HOUR;
            held_btn = BTN_NONE;
            blink    = 1'b0;
            blink_ms = '0;
            idle_ms  = '0;
            return show_view(SHOW_BOTH, 1'b1, BTN_NONE, ST_EDITING);
        end
        if (!editing)
            return show_view(SHOW_NONE, 1'b0, BTN_NONE, ST_IDLE);

        if (held_btn == BTN_NONE)
        begin
            if (pr_i == BTN_OUTSIDE)
                return close_edit(ST_CANCELLED);
            if (pr_i == BTN_SET)
                phase = (phase == PHASE_HOUR) ? PHASE_MINUTE : PHASE_FINAL;
            else if (pr_i == BTN_ADJUST)
            begin
                if (phase == PHASE_HOUR)
                    ed_hour = HOUR_W'((ed_hour + 1) % 24);
                else
                    ed_min = MIN_W'((ed_min + 1) % 60);
            end
            if (pr_i != BTN_NONE)
            begin
                held_btn = pr_i;
                pressed  = 1'b1;
                upd      = 1'b1;
                blink    = 1'b0;
                blink_ms = '0;
                idle_ms  = '0;
            end
        end
        else
        begin
            // a release in the final phase saves before any timer runs
            if (rel_i)
            begin
                held_btn = BTN_NONE;
                if (phase == PHASE_FINAL)
                    return close_edit(ST_SAVED);
            end
            upd = (held_btn == BTN_NONE);
        end

        if (!pressed)
        begin
            blink_ms = timer_add(blink_ms, el_i);
            idle_ms  = timer_add(idle_ms, el_i);
        end
        if (blink_ms > blink_period)
        begin
            blink    = ~blink;
            upd      = 1'b1;
            blink_ms = '0;
        end
        if (idle_ms > idle_timeout)
            return close_edit(ST_TIMEOUT);

        // edited field goes dark in the blink phase
        mask = SHOW_BOTH;
        if (blink)
        begin
            if (phase == PHASE_HOUR)
                mask = SHOW_MINUTE;
            else if (phase == PHASE_MINUTE)
                mask = SHOW_HOUR;
        end
        return show_view(mask, upd, held_btn, ST_EDITING);
    endfunction

    // Register writes, result compare, then prediction of the new item beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period = BLINK_PERIOD_RST;
            idle_timeout = IDLE_TIMEOUT_RST;
            editing      = 1'b0;
            ed_hour      = '0;
            ed_min       = '0;
            phase        = PHASE_HOUR;
            held_btn     = BTN_NONE;
            blink        = 1'b0;
            blink_ms     = '0;
            idle_ms      = '0;
            expected_views.delete();
            errors       = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_BLINK_PERIOD)
                    blink_period = cfg_data;
                else
                    idle_timeout = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_views.pop_front();
                    if (hour !== want.hour)
                        report_mismatch($sformatf("hour %0d, expected %0d", hour, want.hour));
                    if (minute !== want.minute)
                        report_mismatch($sformatf("minute %0d, expected %0d",
                                                  minute, want.minute));
                    if (show_mask !== want.mask)
                        report_mismatch($sformatf("show_mask %0d, expected %0d",
                                                  show_mask, want.mask));
                    if (repaint !== want.repaint)
                        report_mismatch($sformatf("repaint %0d, expected %0d",
                                                  repaint, want.repaint));
                    if (held_button !== want.held)
                        report_mismatch($sformatf("held_button %0d, expected %0d",
                                                  held_button, want.held));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                end
            end

            if (in_valid && !in_stall)
                expected_views.push_back(predict_view(op, start_hour, start_minute,
                                                      press, released, elapsed_ms));
            pending = expected_views.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the clock time-set controller: a directed walk through hour
// and minute edits, wraps, save, cancel and timeout, then random edit
// sessions under several register settings and idle/stall mixes. The checker
// beside the block does all prediction and compare; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
    import ctsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 270;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic              cfg_index    = CFG_BLINK_PERIOD;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              op           = OP_POLL;
    logic [7:0]        start_hour   = '0;
    logic [7:0]        start_minute = '0;
    logic [1:0]        press        = BTN_NONE;
    logic              released     = 1'b0;
    logic [EL_W-1:0]   elapsed_ms   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [1:0]        show_mask;
    logic              repaint;
    logic [1:0]        held_button;
    logic [2:0]        status;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    // Register settings per random phase, extremes included
    int unsigned blink_cfg[6] = '{500, 1, 65535, 1, 65535, 300};
    int unsigned idle_cfg[6]  = '{30000, 1, 65535, 65535, 1, 5000};

    always #5 clk = ~clk;

    clock_time_set_controller DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .start_hour(start_hour), .start_minute(start_minute), .press(press),
        .released(released), .elapsed_ms(elapsed_ms),
        .out_valid(out_valid), .out_stall(out_stall), .hour(hour), .minute(minute),
        .show_mask(show_mask), .repaint(repaint), .held_button(held_button),
        .status(status)
    );

    ctsc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .start_hour(start_hour), .start_minute(start_minute), .press(press),
        .released(released), .elapsed_ms(elapsed_ms),
        .out_valid(out_valid), .out_stall(out_stall), .hour(hour), .minute(minute),
        .show_mask(show_mask), .repaint(repaint), .held_button(held_button),
        .status(status), .errors(errors), .pending(pending)
    );

    // Receiver stalls
    always @(negedge clk)
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // One item beat; valid stays up after the beat until the next call or a drain
    task automatic send_item(input logic op_i, input logic [7:0] hr_i, input logic [7:0] mn_i,
                             input logic [1:0] pr_i, input logic rel_i,
                             input logic [EL_W-1:0] el_i);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_i;
        start_hour   <= hr_i;
        start_minute <= mn_i;
        press        <= pr_i;
        released     <= rel_i;
        elapsed_ms   <= el_i;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Poll beat; hour/minute carry noise since a poll ignores them
    task automatic poll(input logic [1:0] pr_i, input logic rel_i, input logic [EL_W-1:0] el_i);
        send_item(OP_POLL, 8'($urandom_range(255)), 8'($urandom_range(255)), pr_i, rel_i, el_i);
    endtask

    task automatic start_edit(input logic [7:0] hr_i, input logic [7:0] mn_i);
        send_item(OP_START, hr_i, mn_i, 2'($urandom_range(3)), 1'($urandom_range(1)),
                  EL_W'($urandom_range(1023)));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [EL_W-1:0] rand_elapsed();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return EL_W'($urandom_range(40));
        else if (roll < 85)
            return EL_W'($urandom_range(400));
        else if (roll < 95)
            return EL_W'($urandom_range(1023));
        return {EL_W{1'b1}};
    endfunction

    // One edit session: start, a few taps (press, hold, release), some noise
    task automatic run_session();
        int         taps;
        int         roll;
        logic [1:0] pr;
        if ($urandom_range(19) == 0)
            drain();
        start_edit(8'($urandom_range(255)), 8'($urandom_range(255)));
        taps = $urandom_range(1, 8);
        repeat (taps)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                pr = BTN_OUTSIDE;
            else if (roll < 40)
                pr = BTN_SET;
            else
                pr = BTN_ADJUST;
            poll(pr, 1'($urandom_range(1)), rand_elapsed());
            repeat ($urandom_range(0, 3))
                poll(2'($urandom_range(3)), 1'b0, rand_elapsed());
            poll(2'($urandom_range(3)), 1'b1, rand_elapsed());
            repeat ($urandom_range(0, 2))
                poll(BTN_NONE, 1'($urandom_range(1)), rand_elapsed());
            if ($urandom_range(9) == 0)
                send_item(($urandom_range(7) == 0) ? OP_START : OP_POLL,
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          2'($urandom_range(3)), 1'($urandom_range(1)),
                          EL_W'($urandom_range(1023)));
        end
        // sometimes run the idle timer out
        if ($urandom_range(7) == 0)
            repeat (8)
                poll(BTN_NONE, 1'($urandom_range(1)), {EL_W{1'b1}});
    endtask

    initial
    begin
        int phase_end;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed walk with short blink and timeout
        write_cfg(CFG_BLINK_PERIOD, 16'd100);
        write_cfg(CFG_IDLE_TIMEOUT, 16'd2000);
        poll(BTN_SET, 1'b1, 10'd1023);         // ignored while not editing
        start_edit(8'd255, 8'd255);            // both fields reduced
        start_edit(8'd23, 8'd59);              // restart during editing
        poll(BTN_ADJUST, 1'b0, 10'd0);         // hour wraps to zero
        poll(BTN_SET, 1'b0, 10'd50);           // press while held
        poll(BTN_NONE, 1'b1, 10'd50);          // release
        poll(BTN_NONE, 1'b1, 10'd60);          // release with nothing held, blink toggles
        poll(BTN_SET, 1'b0, 10'd0);            // to minute field
        poll(BTN_NONE, 1'b0, 10'd150);         // blink toggle while held
        poll(BTN_NONE, 1'b1, 10'd0);
        poll(BTN_ADJUST, 1'b0, 10'd0);         // minute wraps to zero
        poll(BTN_NONE, 1'b1, 10'd0);
        poll(BTN_SET, 1'b0, 10'd0);            // final phase
        poll(BTN_ADJUST, 1'b1, 10'd1023);      // save on release beats the timers
        start_edit(8'd0, 8'd0);
        poll(BTN_OUTSIDE, 1'b0, 10'd0);        // cancel
        start_edit(8'd12, 8'd30);
        poll(BTN_NONE, 1'b0, 10'd1023);
        poll(BTN_NONE, 1'b0, 10'd1023);        // timeout
        poll(BTN_NONE, 1'b0, 10'd0);
        start_edit(8'd200, 8'd128);
        poll(BTN_SET, 1'b0, 10'd0);
        poll(BTN_OUTSIDE, 1'b0, 10'd10);       // outside while held is ignored
        poll(BTN_NONE, 1'b1, 10'd10);
        poll(BTN_OUTSIDE, 1'b1, 10'd0);

        // Random sessions, one register setting and idle mix per phase
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_cfg(CFG_BLINK_PERIOD, CFG_W'(blink_cfg[p]));
            write_cfg(CFG_IDLE_TIMEOUT, CFG_W'(idle_cfg[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_session();
        end

        drain();
        repeat (5) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
